// ===== src/dlic_pkg.sv =====
// Shared types and constants for the door lock interlock controller.
// No dependencies; every other file imports this package.
`default_nettype none

package dlic_pkg;

  localparam int unsigned TICK_W  = 32;
  localparam int unsigned SPEED_W = 12;
  localparam int unsigned DEB_W   = 8;
  localparam int unsigned CFG_W   = 12;
  localparam int unsigned CFG_IDX_W = 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_TICKS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_AUTOLOCK_SPEED = 1'b1;

  localparam logic [DEB_W-1:0]   DEBOUNCE_RESET = 8'd50;
  localparam logic [SPEED_W-1:0] AUTOLOCK_RESET = 12'd320;

  typedef struct packed {
    logic               lock_button;
    logic               unlock_button;
    logic               ignition_switch;
    logic               door_switch;
    logic [TICK_W-1:0]  now_ticks;
    logic [SPEED_W-1:0] vehicle_speed;
    logic               in_park;
  } item_t;

  typedef struct packed {
    logic lock_changed;
    logic lock_state;
    logic door_is_open;
    logic ignition_on;
    logic override_active;
  } res_t;

  typedef struct packed {
    logic [DEB_W-1:0]   debounce_ticks;
    logic [SPEED_W-1:0] autolock_speed;
  } cfg_t;

endpackage

`default_nettype wire

// ===== src/dlic_ifs.sv =====
// Valid/ready channel interfaces for switch samples and lock results.
// Depends on dlic_pkg for field widths.
`default_nettype none

interface dlic_in_if
  import dlic_pkg::*;
;
  logic               valid;
  logic               ready;
  logic               lock_button;
  logic               unlock_button;
  logic               ignition_switch;
  logic               door_switch;
  logic [TICK_W-1:0]  now_ticks;
  logic [SPEED_W-1:0] vehicle_speed;
  logic               in_park;

  modport source (
    output valid, lock_button, unlock_button, ignition_switch, door_switch,
           now_ticks, vehicle_speed, in_park,
    input  ready
  );
  modport sink (
    input  valid, lock_button, unlock_button, ignition_switch, door_switch,
           now_ticks, vehicle_speed, in_park,
    output ready
  );
endinterface

interface dlic_out_if;
  logic valid;
  logic ready;
  logic lock_changed;
  logic lock_state;
  logic door_is_open;
  logic ignition_on;
  logic override_active;

  modport source (
    output valid, lock_changed, lock_state, door_is_open, ignition_on,
           override_active,
    input  ready
  );
  modport sink (
    input  valid, lock_changed, lock_state, door_is_open, ignition_on,
           override_active,
    output ready
  );
endinterface

`default_nettype wire

// ===== src/dlic_cfg.sv =====
// Configuration registers: debounce interval and auto-lock speed threshold.
// Depends on dlic_pkg.
`default_nettype none

module dlic_cfg
  import dlic_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_addr,
  input  wire logic [CFG_W-1:0]     cfg_wdata,
  output cfg_t                      cfg
);

  logic [DEB_W-1:0]   debounce_r, debounce_nxt;
  logic [SPEED_W-1:0] autolock_r, autolock_nxt;

  always_comb begin
    debounce_nxt = debounce_r;
    autolock_nxt = autolock_r;
    if (cfg_we) begin
      case (cfg_addr)
        CFG_DEBOUNCE_TICKS: debounce_nxt = cfg_wdata[DEB_W-1:0];
        CFG_AUTOLOCK_SPEED: autolock_nxt = cfg_wdata[SPEED_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r <= DEBOUNCE_RESET;
      autolock_r <= AUTOLOCK_RESET;
    end else begin
      debounce_r <= debounce_nxt;
      autolock_r <= autolock_nxt;
    end
  end

  assign cfg.debounce_ticks = debounce_r;
  assign cfg.autolock_speed = autolock_r;

endmodule

`default_nettype wire

// ===== src/dlic_rules.sv =====
// Interlock state and the prioritised rule logic for one sample.
// Depends on dlic_pkg. State advances only when step is high.
`default_nettype none

module dlic_rules
  import dlic_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  step,
  input  wire item_t item,
  input  wire cfg_t  cfg,
  output res_t       res
);

  logic              locked_r, locked_nxt;
  logic              open_r, open_nxt;
  logic              override_r, override_nxt;
  logic              ignition_r, ignition_nxt;
  logic              prev_lock_r, prev_unlock_r, prev_door_r;
  logic [TICK_W-1:0] last_evt_r, last_evt_nxt;

  logic [TICK_W-1:0] elapsed;
  logic              deb_ok_pre, deb_ok, door_evt, moving, done, changed;

  always_comb begin
    elapsed    = item.now_ticks - last_evt_r;
    deb_ok_pre = (elapsed[TICK_W-1:DEB_W] != '0) ||
                 (elapsed[DEB_W-1:0] > cfg.debounce_ticks);
    door_evt   = (item.door_switch != prev_door_r) && deb_ok_pre;
    // a door event restamps the event time, so no button edge counts after it
    deb_ok     = deb_ok_pre && !door_evt;
    moving     = item.vehicle_speed != '0;

    open_nxt     = door_evt ? ~item.door_switch : open_r;
    last_evt_nxt = door_evt ? item.now_ticks : last_evt_r;
    locked_nxt   = locked_r;
    override_nxt = override_r;
    ignition_nxt = ignition_r;
    done         = 1'b0;
    changed      = 1'b0;

    if (item.ignition_switch != ignition_r) begin
      if (!item.ignition_switch && moving) begin
        done = 1'b1;   // switch-off refused while moving
      end else begin
        ignition_nxt = item.ignition_switch & item.in_park;
        if (!ignition_nxt && locked_r) begin
          locked_nxt   = 1'b0;
          override_nxt = 1'b0;
          changed      = 1'b1;
          done         = 1'b1;
        end
      end
    end

    if (!done) begin
      if (!item.lock_button && prev_lock_r && deb_ok && !locked_r) begin
        locked_nxt   = 1'b1;
        override_nxt = 1'b1;
        last_evt_nxt = item.now_ticks;
        changed      = 1'b1;
      end else if (!item.unlock_button && prev_unlock_r && deb_ok && locked_r) begin
        locked_nxt   = 1'b0;
        override_nxt = moving;
        last_evt_nxt = item.now_ticks;
        changed      = 1'b1;
      end else if (!override_r && ignition_nxt &&
                   (item.vehicle_speed > cfg.autolock_speed) && !locked_r) begin
        locked_nxt = 1'b1;
        changed    = 1'b1;
      end
    end

    res.lock_changed    = changed;
    res.lock_state      = locked_nxt;
    res.door_is_open    = open_nxt;
    res.ignition_on     = ignition_nxt;
    res.override_active = override_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      locked_r      <= 1'b0;
      open_r        <= 1'b0;
      override_r    <= 1'b0;
      ignition_r    <= 1'b1;
      prev_lock_r   <= 1'b1;
      prev_unlock_r <= 1'b1;
      prev_door_r   <= 1'b1;
      last_evt_r    <= '0;
    end else if (step) begin
      locked_r      <= locked_nxt;
      open_r        <= open_nxt;
      override_r    <= override_nxt;
      ignition_r    <= ignition_nxt;
      prev_lock_r   <= item.lock_button;
      prev_unlock_r <= item.unlock_button;
      prev_door_r   <= item.door_switch;
      last_evt_r    <= last_evt_nxt;
    end
  end

  // the lock state toggles exactly when a change is reported
  a_changed_toggles: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> ((locked_r != $past(locked_r)) == $past(changed)))
    else $error("lock_changed disagrees with lock state");

  a_hold_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> ($stable(locked_r) && $stable(override_r) && $stable(ignition_r)
               && $stable(last_evt_r)))
    else $error("state moved without a transfer");

  a_no_off_moving: assert property (@(posedge clk) disable iff (!rst_n)
    (step && !item.ignition_switch && moving) |=> (ignition_r == $past(ignition_r)))
    else $error("ignition changed while moving");

  a_override_source: assert property (@(posedge clk) disable iff (!rst_n)
    (step && !changed) |=> !(override_r && !$past(override_r)))
    else $error("override set without a button edge");

endmodule

`default_nettype wire

// ===== src/door_lock_interlock_controller.sv =====
// Door lock interlock controller: usage overview.
//
// in_ch carries one switch sample per transfer: lock and unlock buttons
// (active low), requested ignition, door switch, a 32-bit tick time, the
// speed and a park flag. out_ch returns exactly one result per sample, in
// order: lock_changed, lock_state, door_is_open, ignition_on and
// override_active. cfg_we/cfg_addr/cfg_wdata write debounce_ticks (index 0)
// and autolock_speed (index 1); write only while the block is idle.
//
// A sample sits in an input register, the rules are evaluated in one pass
// of logic, and the result lands in an output register, from which it is
// offered on out_ch. One sample is taken every cycle while out_ch keeps up.
// When out_ch stalls, the held result and one queued sample fill the two
// registers and in_ch.ready drops until the result is taken.
// Synchronous reset (rst_n low) empties both registers and returns the
// interlock state and configuration to their defaults.
`default_nettype none

module door_lock_interlock_controller
  import dlic_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  dlic_in_if.sink                   in_ch,
  dlic_out_if.source                out_ch,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_addr,
  input  wire logic [CFG_W-1:0]     cfg_wdata
);

  logic  in_valid_r, in_valid_nxt;
  item_t in_item_r;
  logic  out_valid_r, out_valid_nxt;
  res_t  out_res_r;
  res_t  res;
  cfg_t  cfg;
  logic  step, in_xfer;

  assign step     = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || step;
  assign in_xfer  = in_ch.valid && in_ch.ready;

  always_comb begin
    in_valid_nxt  = in_xfer ? 1'b1 : (step ? 1'b0 : in_valid_r);
    out_valid_nxt = step ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      in_item_r.lock_button     <= in_ch.lock_button;
      in_item_r.unlock_button   <= in_ch.unlock_button;
      in_item_r.ignition_switch <= in_ch.ignition_switch;
      in_item_r.door_switch     <= in_ch.door_switch;
      in_item_r.now_ticks       <= in_ch.now_ticks;
      in_item_r.vehicle_speed   <= in_ch.vehicle_speed;
      in_item_r.in_park         <= in_ch.in_park;
    end
    if (step) begin
      out_res_r <= res;
    end
  end

  dlic_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  dlic_rules u_rules (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .item  (in_item_r),
    .cfg   (cfg),
    .res   (res)
  );

  assign out_ch.valid           = out_valid_r;
  assign out_ch.lock_changed    = out_res_r.lock_changed;
  assign out_ch.lock_state      = out_res_r.lock_state;
  assign out_ch.door_is_open    = out_res_r.door_is_open;
  assign out_ch.ignition_on     = out_res_r.ignition_on;
  assign out_ch.override_active = out_res_r.override_active;

endmodule

`default_nettype wire

// ===== test/door_lock_interlock_controller_test.sv =====
// Self-checking testbench for door_lock_interlock_controller: predicts every status result
// from the switch samples it sends and compares it field by field under random stalls.
// Depends on dlic_pkg and the dlic_in_if / dlic_out_if channel interfaces.
`default_nettype none

module door_lock_interlock_controller_test;
  import dlic_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 60;
  localparam int PHASE_ITEMS = 100;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_addr;
  logic [CFG_W-1:0]     cfg_wdata;

  dlic_in_if  in_ch ();
  dlic_out_if out_ch ();

  door_lock_interlock_controller dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Predicted interlock state and register copies
  logic               lock_state_q;
  logic               door_open_q;
  logic               override_q;
  logic               ignition_q;
  logic               last_lock_lv;
  logic               last_unlock_lv;
  logic               last_door_lv;
  logic [TICK_W-1:0]  last_event_tick;
  logic [DEB_W-1:0]   debounce_cfg;
  logic [SPEED_W-1:0] autolock_cfg;

  item_t pending_samples[$];
  res_t  expected_status[$];

  // Stimulus generator levels
  logic               gen_lock, gen_unlock, gen_ign, gen_door, gen_park;
  logic [TICK_W-1:0]  gen_tick;
  logic [SPEED_W-1:0] gen_speed;

  logic gaps_on;
  logic receiver_hold;
  logic in_taken  = 1'b0;
  logic out_taken = 1'b0;
  int   send_gap  = 0;
  int   recv_wait = 0;
  int   quiet_cycles = 0;
  int   samples_sent = 0;
  int   results_checked = 0;
  int   failures = 0;

  function automatic logic debounce_elapsed(input logic [TICK_W-1:0] now);
    logic [TICK_W-1:0] diff;
    diff = now - last_event_tick;
    return diff > TICK_W'(debounce_cfg);
  endfunction

  // Rules in priority order; the first one that moves the lock, or a refused switch-off while moving, ends the step.
  function automatic res_t interlock_next(input item_t s);
    logic moving, changed, done;
    res_t r;
    moving  = s.vehicle_speed != '0;
    changed = 1'b0;
    done    = 1'b0;
    if (s.door_switch != last_door_lv && debounce_elapsed(s.now_ticks)) begin
      door_open_q     = ~s.door_switch;
      last_event_tick = s.now_ticks;
    end
    if (s.ignition_switch != ignition_q) begin
      if (!s.ignition_switch && moving) begin
        done = 1'b1;
      end else begin
        // switching on outside park is refused
        ignition_q = s.ignition_switch & s.in_park;
        if (!ignition_q && lock_state_q) begin
          lock_state_q = 1'b0;
          override_q   = 1'b0;
          changed      = 1'b1;
          done         = 1'b1;
        end
      end
    end
    if (!done && !s.lock_button && last_lock_lv && debounce_elapsed(s.now_ticks)
        && !lock_state_q) begin
      lock_state_q    = 1'b1;
      override_q      = 1'b1;
      last_event_tick = s.now_ticks;
      changed         = 1'b1;
      done            = 1'b1;
    end
    if (!done && !s.unlock_button && last_unlock_lv && debounce_elapsed(s.now_ticks)
        && lock_state_q) begin
      lock_state_q    = 1'b0;
      override_q      = moving;
      last_event_tick = s.now_ticks;
      changed         = 1'b1;
      done            = 1'b1;
    end
    if (!done && !override_q && ignition_q && s.vehicle_speed > autolock_cfg
        && !lock_state_q) begin
      lock_state_q = 1'b1;
      changed      = 1'b1;
    end
    last_lock_lv   = s.lock_button;
    last_unlock_lv = s.unlock_button;
    last_door_lv   = s.door_switch;
    r = '{changed, lock_state_q, door_open_q, ignition_q, override_q};
    return r;
  endfunction

  function automatic void compare_bit(input string field, input logic want, input logic got);
    if (got !== want) begin
      $error("%s: expected %0b, got %0b", field, want, got);
      failures++;
    end
  endfunction

  task automatic add_sample(input logic lock_lv, input logic unlock_lv, input logic ign,
                            input logic door, input logic [TICK_W-1:0] tick,
                            input logic [SPEED_W-1:0] speed, input logic park);
    item_t s;
    s = '{lock_lv, unlock_lv, ign, door, tick, speed, park};
    pending_samples.push_back(s);
  endtask

  // Mostly plausible switch traffic with debounce-scale tick steps; one in ten is noise.
  task automatic add_random(input int count);
    logic [63:0] r;
    item_t s;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 9) == 0) begin
        r = {$urandom, $urandom};
        s = r[$bits(item_t)-1:0];
        gen_tick = s.now_ticks;
        pending_samples.push_back(s);
      end else begin
        gen_tick += $urandom_range(0, 2 * debounce_cfg + 2);
        gen_lock   = gen_lock ? ($urandom_range(0, 5) != 0) : 1'($urandom_range(0, 1));
        gen_unlock = gen_unlock ? ($urandom_range(0, 5) != 0) : 1'($urandom_range(0, 1));
        if ($urandom_range(0, 11) == 0) gen_ign = ~gen_ign;
        if ($urandom_range(0, 7) == 0) gen_door = ~gen_door;
        case ($urandom_range(0, 2))
          0: gen_speed = '0;
          1: gen_speed = autolock_cfg + SPEED_W'($urandom_range(0, 2)) - SPEED_W'(1);
          default: gen_speed = SPEED_W'($urandom_range(0, 4095));
        endcase
        gen_park = (gen_speed == '0) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 5) == 0);
        add_sample(gen_lock, gen_unlock, gen_ign, gen_door, gen_tick, gen_speed, gen_park);
      end
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_DEBOUNCE_TICKS) debounce_cfg = value[DEB_W-1:0];
    else autolock_cfg = value[SPEED_W-1:0];
  endtask

  task automatic settle();
    while (pending_samples.size() != 0 || in_ch.valid || expected_status.size() != 0)
      @(posedge clk);
  endtask

  // Sample driver
  always @(negedge clk) begin : drive_samples
    item_t s;
    if (rst_n && (!in_ch.valid || in_taken)) begin
      if (send_gap != 0) begin
        send_gap    <= send_gap - 1;
        in_ch.valid <= 1'b0;
      end else if (pending_samples.size() != 0) begin
        s = pending_samples.pop_front();
        in_ch.lock_button     <= s.lock_button;
        in_ch.unlock_button   <= s.unlock_button;
        in_ch.ignition_switch <= s.ignition_switch;
        in_ch.door_switch     <= s.door_switch;
        in_ch.now_ticks       <= s.now_ticks;
        in_ch.vehicle_speed   <= s.vehicle_speed;
        in_ch.in_park         <= s.in_park;
        in_ch.valid           <= 1'b1;
        send_gap              <= gaps_on ? $urandom_range(0, 8) : 0;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Result receiver: fresh stall per result
  always @(negedge clk) begin : drive_ready
    int w;
    if (rst_n) begin
      if (receiver_hold) begin
        out_ch.ready <= 1'b0;
      end else if (out_taken) begin
        w = gaps_on ? $urandom_range(0, 8) : 0;
        recv_wait    <= (w > 0) ? w - 1 : 0;
        out_ch.ready <= (w == 0);
      end else if (recv_wait != 0) begin
        recv_wait    <= recv_wait - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Transfer tracking, checking and watchdog
  always @(posedge clk) begin : track_transfers
    item_t s;
    res_t  want;
    logic  in_xfer, out_xfer;
    in_xfer   = rst_n && in_ch.valid && in_ch.ready;
    out_xfer  = rst_n && out_ch.valid && out_ch.ready;
    in_taken  <= in_xfer;
    out_taken <= out_xfer;
    if (out_xfer) begin
      results_checked++;
      if (expected_status.size() == 0) begin
        $error("unexpected result transfer with nothing outstanding");
        failures++;
      end else begin
        want = expected_status.pop_front();
        compare_bit("lock_changed", want.lock_changed, out_ch.lock_changed);
        compare_bit("lock_state", want.lock_state, out_ch.lock_state);
        compare_bit("door_is_open", want.door_is_open, out_ch.door_is_open);
        compare_bit("ignition_on", want.ignition_on, out_ch.ignition_on);
        compare_bit("override_active", want.override_active, out_ch.override_active);
      end
    end
    if (in_xfer) begin
      s = '{in_ch.lock_button, in_ch.unlock_button, in_ch.ignition_switch,
            in_ch.door_switch, in_ch.now_ticks, in_ch.vehicle_speed, in_ch.in_park};
      expected_status.push_back(interlock_next(s));
      samples_sent++;
    end
    if (in_xfer || out_xfer) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles == STALL_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles, %0d results outstanding",
               STALL_LIMIT, expected_status.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin : stimulus
    logic [DEB_W-1:0]   deb_plan   [5];
    logic [SPEED_W-1:0] speed_plan [5];
    rst_n                 = 1'b0;
    cfg_we                = 1'b0;
    cfg_addr              = CFG_DEBOUNCE_TICKS;
    cfg_wdata             = '0;
    in_ch.valid           = 1'b0;
    in_ch.lock_button     = 1'b1;
    in_ch.unlock_button   = 1'b1;
    in_ch.ignition_switch = 1'b1;
    in_ch.door_switch     = 1'b1;
    in_ch.now_ticks       = '0;
    in_ch.vehicle_speed   = '0;
    in_ch.in_park         = 1'b1;
    out_ch.ready          = 1'b0;
    gaps_on               = 1'b0;
    receiver_hold         = 1'b0;

    lock_state_q    = 1'b0;
    door_open_q     = 1'b0;
    override_q      = 1'b0;
    ignition_q      = 1'b1;
    last_lock_lv    = 1'b1;
    last_unlock_lv  = 1'b1;
    last_door_lv    = 1'b1;
    last_event_tick = '0;
    debounce_cfg    = DEBOUNCE_RESET;
    autolock_cfg    = AUTOLOCK_RESET;

    gen_lock   = 1'b1;
    gen_unlock = 1'b1;
    gen_ign    = 1'b1;
    gen_door   = 1'b1;
    gen_park   = 1'b1;
    gen_tick   = '0;
    gen_speed  = '0;

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // Directed interlock cases at the reset settings
    add_sample(1'b1, 1'b1, 1'b1, 1'b1, 32'd0,   12'd0,    1'b1);  // quiet sample
    // press exactly at debounce: ignored
    add_sample(1'b0, 1'b1, 1'b1, 1'b1, 32'd50,  12'd0,    1'b1);
    add_sample(1'b1, 1'b1, 1'b1, 1'b1, 32'd50,  12'd0,    1'b1);
    add_sample(1'b0, 1'b1, 1'b1, 1'b1, 32'd51,  12'd0,    1'b1);  // first debounced lock
    // unlock inside debounce window
    add_sample(1'b1, 1'b0, 1'b1, 1'b1, 32'd80,  12'd0,    1'b1);
    add_sample(1'b1, 1'b1, 1'b1, 1'b1, 32'd90,  12'd0,    1'b1);
    // lock edge on locked doors falls through
    add_sample(1'b0, 1'b0, 1'b1, 1'b1, 32'd200, 12'd0,    1'b1);
    add_sample(1'b1, 1'b1, 1'b1, 1'b0, 32'd300, 12'd0,    1'b1);  // door opens
    add_sample(1'b1, 1'b1, 1'b1, 1'b1, 32'd320, 12'd0,    1'b1);  // door bounce ignored
    // auto-lock just above threshold
    add_sample(1'b1, 1'b1, 1'b1, 1'b1, 32'd400, 12'd321,  1'b0);
    // unlock while moving sets override
    add_sample(1'b1, 1'b0, 1'b1, 1'b1, 32'd500, 12'd100,  1'b0);
    // override blocks auto-lock
    add_sample(1'b1, 1'b1, 1'b1, 1'b1, 32'd510, 12'd4095, 1'b0);
    // ignition off while moving refused
    add_sample(1'b1, 1'b1, 1'b0, 1'b1, 32'd520, 12'd4095, 1'b0);
    add_sample(1'b0, 1'b1, 1'b1, 1'b1, 32'd600, 12'd0,    1'b1);
    add_sample(1'b1, 1'b1, 1'b0, 1'b1, 32'd610, 12'd0,    1'b1);  // ignition off unlocks
    add_sample(1'b0, 1'b1, 1'b0, 1'b1, 32'd700, 12'd0,    1'b1);
    // ignition on outside park forced off
    add_sample(1'b1, 1'b1, 1'b1, 1'b1, 32'd710, 12'd0,    1'b0);
    add_sample(1'b1, 1'b1, 1'b1, 1'b1, 32'd720, 12'd0,    1'b1);  // ignition on in park
    // speed at threshold: no auto-lock
    add_sample(1'b1, 1'b1, 1'b1, 1'b1, 32'd730, 12'd320,  1'b0);
    // unlock edge on unlocked doors, then auto-lock
    add_sample(1'b1, 1'b0, 1'b1, 1'b1, 32'd800, 12'd321,  1'b0);
    add_sample(1'b1, 1'b1, 1'b1, 1'b0, 32'hFFFF_FFF0, 12'd0, 1'b1);
    // across the wrap, exactly at debounce
    add_sample(1'b1, 1'b1, 1'b1, 1'b1, 32'h0000_0022, 12'd0, 1'b1);
    add_sample(1'b1, 1'b1, 1'b1, 1'b0, 32'h0000_0024, 12'd0, 1'b1);
    add_sample(1'b1, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF, 12'd0, 1'b1);
    settle();

    deb_plan[0] = 8'd0;   speed_plan[0] = 12'd4095;
    deb_plan[1] = 8'd255; speed_plan[1] = 12'd0;
    deb_plan[2] = 8'd3;   speed_plan[2] = 12'd16;
    deb_plan[3] = DEB_W'($urandom_range(0, 255));
    speed_plan[3] = SPEED_W'($urandom_range(0, 4095));
    deb_plan[4] = DEBOUNCE_RESET; speed_plan[4] = AUTOLOCK_RESET;

    for (int p = 0; p < 5; p++) begin
      write_reg(CFG_DEBOUNCE_TICKS, CFG_W'(deb_plan[p]));
      write_reg(CFG_AUTOLOCK_SPEED, CFG_W'(speed_plan[p]));
      gaps_on = (p != 1);  // one phase runs back to back on both sides
      add_random(PHASE_ITEMS);
      if (p == 2) begin
        // hold the output off so the block fills and back-pressures its input
        @(posedge clk);
        receiver_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        receiver_hold = 1'b0;
      end
      settle();
    end

    repeat (4) @(posedge clk);
    $display("Sent %0d switch samples and checked %0d status results over 6 register settings,",
             samples_sent, results_checked);
    $display("covering debounce edges, tick wrap, ignition interlocks, auto-lock and stalls.");
    if (failures == 0 && expected_status.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire
